// File: sv/tstd_pkg.sv
// ----------------------------------------------------------------------------
// tstd_pkg
// Shared constants for the task switch trace with distinct-task dump.
// ----------------------------------------------------------------------------
package tstd_pkg;

  localparam int TRACE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  localparam logic LK_SEQ    = 1'b0;
  localparam logic LK_DIST   = 1'b1;

endpackage

// File: sv/task_switch_trace_dedup_top.sv
// ----------------------------------------------------------------------------
// task_switch_trace_dedup_top
// Circular trace of task switches; dump emits newest-first list, then the
// distinct tasks in order of first appearance in that list.
// ----------------------------------------------------------------------------
//  channel  | handshake               | word
//  in       | start / busy            | in_operation, in_from_task, in_to_task
//  out      | out_strobe (no stall)   | out_list_kind, out_position,
//           |                         | out_task_id, out_last
//
//  The first record after reset makes two writes (from-task, then to-task)
//  through the single trace memory write port; later records write once.
//  A dump holds busy through the newest-first list, the distinct search and
//  the distinct list; the distinct search reads the scratch memory one entry
//  per cycle. Each memory read is registered, then the output word is
//  registered. Sync reset clears write pointer, full flag, distinct count
//  and state; memories are not cleared.
// ----------------------------------------------------------------------------
module task_switch_trace_dedup_top #(
  parameter int TRACE_DEPTH = tstd_pkg::TRACE_DEPTH_DEF,
  parameter int ID_BITS     = tstd_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_from_task,
  input  logic [15:0] in_to_task,
  output logic        out_strobe,
  output logic        out_list_kind,
  output logic [3:0]  out_position,
  output logic [15:0] out_task_id,
  output logic        out_last
);

  localparam int PW = $clog2(TRACE_DEPTH);
  localparam int CW = $clog2(TRACE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_REC2, S_SEQ, S_D_RD, S_D_CAND, S_D_CMP, S_DOUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       wp_r, wp_nxt;
  logic                full_r, full_nxt;
  logic [ID_BITS-1:0]  hold_r, hold_nxt;
  logic [CW-1:0]       total_r, total_nxt;
  logic [PW-1:0]       rp_r, rp_nxt;
  logic [PW-1:0]       i_r, i_nxt;
  logic [PW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       dcnt_r, dcnt_nxt;
  logic [ID_BITS-1:0]  cand_r, cand_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                pend_kind_r, pend_kind_nxt;
  logic [3:0]          pend_pos_r, pend_pos_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                out_strobe_r;
  logic                out_kind_r;
  logic [3:0]          out_pos_r;
  logic [15:0]         out_id_r;
  logic                out_last_r;

  logic [ID_BITS-1:0]  trace_mem [TRACE_DEPTH];
  logic [ID_BITS-1:0]  scr_mem [TRACE_DEPTH];
  logic [ID_BITS-1:0]  trace_q_r;
  logic [ID_BITS-1:0]  scr_q_r;

  logic                tw_en;
  logic [PW-1:0]       tw_addr;
  logic [ID_BITS-1:0]  tw_data;
  logic                sw_en;
  logic [PW-1:0]       sw_addr;
  logic [ID_BITS-1:0]  sw_data;
  logic [PW-1:0]       scr_ra;

  logic [PW-1:0]       rp_dec;
  logic [PW-1:0]       wp_inc;
  logic                wp_wrap;
  logic [CW-1:0]       total_now;
  logic                i_done;

  assign busy      = (state_r != S_IDLE);
  assign wp_wrap   = (wp_r == PW'(TRACE_DEPTH - 1));
  assign wp_inc    = wp_wrap ? '0 : wp_r + 1'b1;
  assign rp_dec    = (rp_r == '0) ? PW'(TRACE_DEPTH - 1) : rp_r - 1'b1;
  assign total_now = full_r ? CW'(TRACE_DEPTH) : CW'(wp_r);
  assign i_done    = ((CW'(i_r) + CW'(1)) == total_r);

  // trace memory: write port, read port at rp_dec
  always_ff @(posedge clk) begin
    if (tw_en) begin
      trace_mem[tw_addr] <= tw_data;
    end
    trace_q_r <= trace_mem[rp_dec];
  end

  // distinct scratch memory
  always_ff @(posedge clk) begin
    if (sw_en) begin
      scr_mem[sw_addr] <= sw_data;
    end
    scr_q_r <= scr_mem[scr_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    full_nxt      = full_r;
    hold_nxt      = hold_r;
    total_nxt     = total_r;
    rp_nxt        = rp_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    dcnt_nxt      = dcnt_r;
    cand_nxt      = cand_r;
    pend_vld_nxt  = 1'b0;
    pend_kind_nxt = pend_kind_r;
    pend_pos_nxt  = pend_pos_r;
    pend_last_nxt = 1'b0;
    tw_en         = 1'b0;
    tw_addr       = wp_r;
    tw_data       = ID_BITS'(in_to_task);
    sw_en         = 1'b0;
    sw_addr       = dcnt_r[PW-1:0];
    sw_data       = cand_r;
    scr_ra        = j_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == tstd_pkg::OP_RECORD) begin
            tw_en    = 1'b1;
            wp_nxt   = wp_inc;
            full_nxt = full_r | wp_wrap;
            if (wp_r == '0 && !full_r) begin
              tw_data   = ID_BITS'(in_from_task);
              hold_nxt  = ID_BITS'(in_to_task);
              state_nxt = S_REC2;
            end
          end else if (total_now != '0) begin
            total_nxt = total_now;
            rp_nxt    = wp_r;
            i_nxt     = '0;
            state_nxt = S_SEQ;
          end
        end
      end
      S_REC2: begin
        tw_en     = 1'b1;
        tw_data   = hold_r;
        wp_nxt    = wp_inc;
        full_nxt  = full_r | wp_wrap;
        state_nxt = S_IDLE;
      end
      S_SEQ: begin
        rp_nxt        = rp_dec;
        pend_vld_nxt  = 1'b1;
        pend_kind_nxt = tstd_pkg::LK_SEQ;
        pend_pos_nxt  = 4'(i_r);
        if (i_done) begin
          i_nxt     = '0;
          rp_nxt    = wp_r;
          dcnt_nxt  = '0;
          state_nxt = S_D_RD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_D_RD: begin
        rp_nxt    = rp_dec;
        state_nxt = S_D_CAND;
      end
      S_D_CAND: begin
        cand_nxt = trace_q_r;
        if (dcnt_r == '0) begin
          sw_en    = 1'b1;
          sw_addr  = '0;
          sw_data  = trace_q_r;
          dcnt_nxt = CW'(1);
          if (i_done) begin
            j_nxt     = '0;
            state_nxt = S_DOUT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_D_RD;
          end
        end else begin
          j_nxt     = '0;
          scr_ra    = '0;
          state_nxt = S_D_CMP;
        end
      end
      S_D_CMP: begin
        if (scr_q_r == cand_r || (CW'(j_r) + CW'(1)) == dcnt_r) begin
          if (scr_q_r != cand_r) begin
            sw_en    = 1'b1;
            dcnt_nxt = dcnt_r + 1'b1;
          end
          if (i_done) begin
            j_nxt     = '0;
            state_nxt = S_DOUT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_D_RD;
          end
        end else begin
          j_nxt  = j_r + 1'b1;
          scr_ra = j_r + 1'b1;
        end
      end
      S_DOUT: begin
        scr_ra        = j_r;
        pend_vld_nxt  = 1'b1;
        pend_kind_nxt = tstd_pkg::LK_DIST;
        pend_pos_nxt  = 4'(j_r);
        if ((CW'(j_r) + CW'(1)) == dcnt_r) begin
          pend_last_nxt = 1'b1;
          j_nxt         = '0;
          state_nxt     = S_IDLE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wp_r         <= '0;
      full_r       <= 1'b0;
      dcnt_r       <= '0;
      pend_vld_r   <= 1'b0;
      pend_last_r  <= 1'b0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      full_r       <= full_nxt;
      dcnt_r       <= dcnt_nxt;
      pend_vld_r   <= pend_vld_nxt;
      pend_last_r  <= pend_last_nxt;
      out_strobe_r <= pend_vld_r;
      out_last_r   <= pend_vld_r & pend_last_r;
    end
    hold_r      <= hold_nxt;
    total_r     <= total_nxt;
    rp_r        <= rp_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    cand_r      <= cand_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_pos_r  <= pend_pos_nxt;
    out_kind_r  <= pend_kind_r;
    out_pos_r   <= pend_pos_r;
    out_id_r    <= (pend_kind_r == tstd_pkg::LK_DIST) ? 16'(scr_q_r) : 16'(trace_q_r);
  end

  assign out_strobe    = out_strobe_r;
  assign out_list_kind = out_kind_r;
  assign out_position  = out_pos_r;
  assign out_task_id   = out_id_r;
  assign out_last      = out_last_r;

endmodule

// File: sv/tstd_checker.sv
// ----------------------------------------------------------------------------
// tstd_checker
// Port-level checks for the task switch trace, bound to the top level.
// ----------------------------------------------------------------------------
module tstd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_list_kind,
  input logic [3:0] out_position,
  input logic       out_last
);

  // last only on a valid word
  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe)
    else $error("out_last without out_strobe");

  // busy only follows an accepted command
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // newest-first entries stream without gaps
  a_seq_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_list_kind == tstd_pkg::LK_SEQ && out_position != 4'd0)
      |-> $past(out_strobe))
    else $error("gap inside newest-first list");

  // a dump ends with a distinct entry
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> (out_list_kind == tstd_pkg::LK_DIST))
    else $error("last word not a distinct entry");

  // quiet cycle after the end of a dump
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_strobe)
    else $error("word right after last");

endmodule

bind task_switch_trace_dedup_top tstd_checker u_tstd_checker (.*);
